>>> sv/fjva_pkg.sv
// Shared constants and types for the filtered joint velocity/acceleration block.
// No dependencies.
package fjva_pkg;

  localparam int unsigned JointsDefault = 4;
  localparam int unsigned SampleW       = 32;
  localparam int unsigned TauW          = 24;
  localparam logic [TauW-1:0] TauReset  = 24'd63662;
  localparam int unsigned AlphaBits     = 30;
  localparam int unsigned DivNumW       = 64;
  localparam int unsigned DivDenW       = 33;
  localparam logic [19:0] UsPerS        = 20'd1000000;

  typedef struct packed {
    logic first;       // store first sample position
    logic rate_pos;    // start raw velocity divide
    logic rate_vel;    // start acceleration divide, commit new filtered velocity
    logic take_first;  // filtered <= raw, accel <= 0
    logic mul;         // delta * alpha
    logic upd;         // form new filtered velocity
    logic take_acc;    // accel <= divide result
  } lane_cmd_t;

endpackage

>>> sv/fjva_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on fjva_pkg.
module fjva_div import fjva_pkg::*; #(
  parameter int unsigned NUM_W = DivNumW,
  parameter int unsigned DEN_W = DivDenW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NUM_W);

  logic [NUM_W-1:0] sr_q, sr_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   trial, diff;
  logic             qbit;

  assign trial = {rem_q, sr_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = ~diff[DEN_W];

  always_comb begin
    sr_d   = sr_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      sr_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NUM_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sr_d  = {sr_q[NUM_W-2:0], qbit};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = sr_q;

endmodule

>>> sv/fjva_lane.sv
// One joint lane: backward difference, lowpass update and acceleration.
// Depends on fjva_pkg and fjva_div.
module fjva_lane import fjva_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_cmd_t          cmd_i,
  input  logic signed [31:0] pos_i,
  input  logic [31:0]        dt_i,
  input  logic [AlphaBits:0] alpha_i,
  output logic               done_o,
  output logic signed [31:0] vel_o,
  output logic signed [31:0] acc_o
);

  logic signed [31:0] prev_pos_q, filt_q, acc_q, nf_q;
  logic [63:0]        prod_q;
  logic               dneg_q, rneg_q;

  logic signed [32:0] rdiff;
  logic [32:0]        rmag;
  logic [52:0]        rprod;
  logic [63:0]        rnum, quo;
  logic               rstart, big, sat;
  logic signed [31:0] rate;
  logic signed [32:0] delta;
  logic [32:0]        dmag;
  logic [63:0]        prod_w, rsum;
  logic [33:0]        step;
  logic signed [34:0] nsum;
  logic signed [31:0] nf_w;

  assign rdiff  = cmd_i.rate_vel ? (33'(nf_q) - 33'(filt_q)) : (33'(pos_i) - 33'(prev_pos_q));
  assign rmag   = rdiff[32] ? 33'(-rdiff) : 33'(rdiff);
  assign rprod  = {20'b0, rmag} * {33'b0, UsPerS};
  assign rnum   = {11'b0, rprod} + {33'b0, dt_i[31:1]};
  assign rstart = cmd_i.rate_pos | cmd_i.rate_vel;

  fjva_div #(.NUM_W(DivNumW), .DEN_W(DivDenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rstart),
    .num_i   (rnum),
    .den_i   ({1'b0, dt_i}),
    .done_o  (done_o),
    .quo_o   (quo)
  );

  always_comb begin
    big = |quo[63:32];
    if (rneg_q) begin
      sat  = big | (quo[31] & (|quo[30:0]));
      rate = sat ? 32'sh8000_0000 : $signed(-quo[31:0]);
    end else begin
      sat  = big | quo[31];
      rate = sat ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end
  end

  assign delta  = 33'(rate) - 33'(filt_q);
  assign dmag   = delta[32] ? 33'(-delta) : 33'(delta);
  assign prod_w = {31'b0, dmag} * {33'b0, alpha_i};

  assign rsum = prod_q + (64'd1 << (AlphaBits - 1));
  assign step = rsum[AlphaBits+33:AlphaBits];
  assign nsum = dneg_q ? (35'(filt_q) - $signed({1'b0, step}))
                       : (35'(filt_q) + $signed({1'b0, step}));
  assign nf_w = (nsum[34:31] != {4{nsum[34]}}) ?
                (nsum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : nsum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      filt_q     <= '0;
      acc_q      <= '0;
    end else begin
      if (cmd_i.first || cmd_i.rate_pos) prev_pos_q <= pos_i;
      if (cmd_i.take_first) begin
        filt_q <= rate;
        acc_q  <= '0;
      end
      if (cmd_i.rate_vel) filt_q <= nf_q;
      if (cmd_i.take_acc) acc_q <= rate;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rstart) rneg_q <= rdiff[32];
    if (cmd_i.mul) begin
      prod_q <= prod_w;
      dneg_q <= delta[32];
    end
    if (cmd_i.upd) nf_q <= nf_w;
  end

  assign vel_o = filt_q;
  assign acc_o = acc_q;

endmodule

>>> sv/filtered_joint_velocity_accel_top.sv
// Top level: sequencer, shared lowpass weight divider, joint lanes, output register.
// Depends on fjva_pkg, fjva_lane and fjva_div.

// Each sample carries a microsecond timestamp and JOINTS Q16.16 positions. The first
// sample primes the state and gives no result; the block is ready again the next cycle.
// The second gives two results, raw velocity with zero acceleration. Later samples give
// one filtered result: every lane runs its 64-step bit-serial divider twice (velocity,
// then acceleration), with the lowpass weight divided alongside the first pass, plus
// sequencer states for the weight multiply and the lowpass update. A zero time step
// gives one held result with time_error. One sample is in flight at a time and the next
// is taken once the last result enters the output register, so stalls on the result
// side delay the next sample.
module filtered_joint_velocity_accel_top import fjva_pkg::*; #(
  parameter int unsigned JOINTS = JointsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [TauW-1:0]               cfg_data_i,    // filter_time_constant_us
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_time, position_joint0 .. position_joint(JOINTS-1)
  input  logic [SampleW+32*JOINTS-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // velocity_joint0 .. velocity_joint(JOINTS-1), accel_joint0 .. accel_joint(JOINTS-1)
  output logic [64*JOINTS-1:0]          m_axis_tdata,
  output logic                          m_axis_tlast,  // last_of_run
  output logic                          m_axis_tuser   // time_error
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV1   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_UPD    = 4'd3;
  localparam logic [3:0] ST_ACC    = 4'd4;
  localparam logic [3:0] ST_DIV2   = 4'd5;
  localparam logic [3:0] ST_EMIT_A = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;
  localparam logic [3:0] ST_HOLD   = 4'd8;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  logic [3:0]          state_q, state_d;
  logic [1:0]          phase_q, phase_d;
  logic [TauW-1:0]     tau_q;
  logic [31:0]         prev_time_q, prev_time_d, dt_q, dt_d, dt_w, lane_dt;
  logic                m_valid_q, m_valid_d, m_last_q, m_last_d, m_err_q, m_err_d;
  logic [64*JOINTS-1:0] m_data_q, m_data_d;
  logic                s_accept, slot_free, load;
  lane_cmd_t           cmd;
  logic                alpha_start, alpha_done;
  logic [32:0]         alpha_den;
  logic [63:0]         alpha_num, alpha_quo;
  logic [JOINTS-1:0]   lane_done;
  logic [64*JOINTS-1:0] lane_data;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign slot_free     = ~m_valid_q | m_axis_tready;
  assign dt_w          = s_axis_tdata[SampleW-1:0] - prev_time_q;
  assign lane_dt       = (state_q == ST_IDLE) ? dt_w : dt_q;

  assign alpha_den = {9'b0, tau_q} + {1'b0, dt_w};
  assign alpha_num = ({32'b0, dt_w} << AlphaBits) + {31'b0, alpha_den[32:1]};

  fjva_div #(.NUM_W(DivNumW), .DEN_W(DivDenW)) u_alpha_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alpha_start),
    .num_i   (alpha_num),
    .den_i   (alpha_den),
    .done_o  (alpha_done),
    .quo_o   (alpha_quo)
  );

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    fjva_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (s_axis_tdata[SampleW+32*j +: 32]),
      .dt_i    (lane_dt),
      .alpha_i (alpha_quo[AlphaBits:0]),
      .done_o  (lane_done[j]),
      .vel_o   (lane_data[32*j +: 32]),
      .acc_o   (lane_data[32*(JOINTS+j) +: 32])
    );
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    prev_time_d = prev_time_q;
    dt_d        = dt_q;
    cmd         = '0;
    alpha_start = 1'b0;
    load        = 1'b0;
    m_last_d    = m_last_q;
    m_err_d     = m_err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (phase_q == PH_NONE) begin
            cmd.first   = 1'b1;
            prev_time_d = s_axis_tdata[SampleW-1:0];
            phase_d     = PH_ONE;
          end else if (dt_w == '0) begin
            state_d = ST_HOLD;
          end else begin
            cmd.rate_pos = 1'b1;
            alpha_start  = 1'b1;
            prev_time_d  = s_axis_tdata[SampleW-1:0];
            dt_d         = dt_w;
            state_d      = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if ((&lane_done) && alpha_done) begin
          if (phase_q == PH_ONE) begin
            cmd.take_first = 1'b1;
            phase_d        = PH_RUN;
            state_d        = ST_EMIT_A;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd.rate_vel = 1'b1;
        state_d      = ST_DIV2;
      end
      ST_DIV2: begin
        if (&lane_done) begin
          cmd.take_acc = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT_A: begin
        if (slot_free) begin
          load     = 1'b1;
          m_last_d = 1'b0;
          m_err_d  = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load     = 1'b1;
          m_last_d = 1'b1;
          m_err_d  = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          load     = 1'b1;
          m_last_d = 1'b1;
          m_err_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    m_data_d = load ? lane_data : m_data_q;
    if (load) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
    else m_valid_d = m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_NONE;
      tau_q       <= TauReset;
      prev_time_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      prev_time_q <= prev_time_d;
      m_valid_q   <= m_valid_d;
      if (cfg_valid_i) tau_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_err_q  <= m_err_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_err_q;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_err_q |-> m_last_q)
    else $error("time error item not marked last");
  a_first_primes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && phase_q == PH_NONE |=> state_q == ST_IDLE && phase_q == PH_ONE)
    else $error("first sample did not just prime state");
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV1 && alpha_done |-> alpha_quo <= (64'd1 << AlphaBits))
    else $error("lowpass weight above one");
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("bad start phase");
`endif

endmodule
